// ===== rtl/slp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slp_pkg - shared types and constants for the sorted slot list
// Pool size, link encoding, command and status codes, memory request
// structs and small helpers used by the sequencer and the link store.
// ----------------------------------------------------------------------------
package slp_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LINK_W      = $clog2(SLOTS + 1);
    localparam int DATA_W      = 32;
    localparam int SLOT_PORT_W = 4;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SLOTS);
    localparam logic [LINK_W-1:0] LAST_CNT = LINK_W'(SLOTS - 1);

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_FH,
        S_WALK,
        S_LINK,
        S_LINK_PREV,
        S_INS_DONE,
        S_RD,
        S_RD_OUT
    } state_t;

    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
    } val_req_t;

    typedef struct packed {
        logic              clr;
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [LINK_W-1:0] wdata;
    } link_req_t;

    // link of a slot as it stands after reset or clear
    function automatic logic [LINK_W-1:0] reset_link(input logic [SLOT_W-1:0] idx);
        logic [LINK_W-1:0] res;
        if (idx == SLOT_W'(SLOTS - 1))
            res = NIL_LINK;
        else
            res = LINK_W'(idx) + LINK_W'(1);
        return res;
    endfunction

    // low bits of a slot index as carried on the result port
    function automatic logic [SLOT_PORT_W-1:0] slot_port(input logic [LINK_W-1:0] l);
        logic [LINK_W+SLOT_PORT_W-1:0] ext;
        ext = {{SLOT_PORT_W{1'b0}}, l};
        return ext[SLOT_PORT_W-1:0];
    endfunction

endpackage

// ===== rtl/slp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slp_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module slp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/slp_link_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slp_link_store - link memory with reset chain
// Link RAM plus one valid flag per slot; a slot not written since reset
// or clear reads as its reset link, so clear needs no sweep of the RAM.
// ----------------------------------------------------------------------------
module slp_link_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  slp_pkg::link_req_t        req,
    output logic [slp_pkg::LINK_W-1:0] rdata
);
    import slp_pkg::*;

    logic [SLOTS-1:0]  vld_reg;
    logic              rd_vld_reg;
    logic [SLOT_W-1:0] rd_addr_reg;
    logic [LINK_W-1:0] ram_rdata;

    slp_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .re    (req.re),
        .raddr (req.raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                vld_reg <= '0;
            end
            else if (req.we)
            begin
                vld_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rd_vld_reg <= vld_reg[req.raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_addr_reg <= req.raddr;
        end
    end

    assign rdata = rd_vld_reg ? ram_rdata : reset_link(rd_addr_reg);

endmodule

// ===== rtl/slp_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slp_seq - list sequencer
// Holds the free and list heads, walks the chain through the value and
// link memories, relinks on insert and streams readouts into the result
// register.
// ----------------------------------------------------------------------------
module slp_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [1:0]                        func,
    input  logic signed [slp_pkg::DATA_W-1:0] value,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [slp_pkg::DATA_W-1:0] out_value,
    output logic [slp_pkg::SLOT_PORT_W-1:0]   slot,
    output logic [1:0]                        status,
    output logic                              last,
    output slp_pkg::val_req_t                 val_req,
    output slp_pkg::link_req_t                link_req,
    input  logic [slp_pkg::DATA_W-1:0]        val_rdata,
    input  logic [slp_pkg::LINK_W-1:0]        link_rdata
);
    import slp_pkg::*;

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [SLOT_W-1:0] r_reg, r_next;
    logic [SLOT_W-1:0] prev_reg, prev_next;
    logic              has_prev_reg, has_prev_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] cnt_reg, cnt_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] list_head_reg, list_head_next;

    logic                     res_valid_reg;
    logic [DATA_W-1:0]        res_value_reg;
    logic [SLOT_PORT_W-1:0]   res_slot_reg;
    logic [1:0]               res_status_reg;
    logic                     res_last_reg;

    logic                   out_free;
    logic                   em;
    logic [DATA_W-1:0]      em_value;
    logic [SLOT_PORT_W-1:0] em_slot;
    logic [1:0]             em_status;
    logic                   em_last;
    logic                   less;
    logic                   fin;

    assign out_free = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign less = $signed(val_rdata) < $signed(val_reg);
    assign fin = (link_rdata >= NIL_LINK) || (cnt_reg == LAST_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            list_head_reg <= NIL_LINK;
            has_prev_reg  <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
            has_prev_reg  <= has_prev_next;
            cnt_reg       <= cnt_next;
            if (em)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        r_reg    <= r_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        if (em)
        begin
            res_value_reg  <= em_value;
            res_slot_reg   <= em_slot;
            res_status_reg <= em_status;
            res_last_reg   <= em_last;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        r_next         = r_reg;
        prev_next      = prev_reg;
        has_prev_next  = has_prev_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        free_head_next = free_head_reg;
        list_head_next = list_head_reg;
        val_req        = '0;
        link_req       = '0;
        em             = 1'b0;
        em_value       = val_reg;
        em_slot        = '0;
        em_status      = STAT_OK;
        em_last        = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    val_next = value;
                    priority case (func)
                        FUNC_INSERT: state_next = S_INS;
                        FUNC_READ:   state_next = S_RD;
                        FUNC_CLEAR:
                        begin
                            link_req.clr   = 1'b1;
                            free_head_next = '0;
                            list_head_next = NIL_LINK;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            S_INS:
            begin
                if (free_head_reg >= NIL_LINK)
                begin
                    em_status = STAT_FULL;
                    if (out_free)
                    begin
                        em         = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    r_next         = free_head_reg[SLOT_W-1:0];
                    val_req.we     = 1'b1;
                    val_req.waddr  = free_head_reg[SLOT_W-1:0];
                    val_req.wdata  = val_reg;
                    link_req.re    = 1'b1;
                    link_req.raddr = free_head_reg[SLOT_W-1:0];
                    state_next     = S_INS_FH;
                end
            end

            S_INS_FH:
            begin
                free_head_next = link_rdata;
                cur_next       = list_head_reg;
                has_prev_next  = 1'b0;
                cnt_next       = '0;
                if (list_head_reg >= NIL_LINK)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    val_req.re     = 1'b1;
                    val_req.raddr  = list_head_reg[SLOT_W-1:0];
                    link_req.re    = 1'b1;
                    link_req.raddr = list_head_reg[SLOT_W-1:0];
                    state_next     = S_WALK;
                end
            end

            S_WALK:
            begin
                if (less)
                begin
                    prev_next     = cur_reg[SLOT_W-1:0];
                    has_prev_next = 1'b1;
                    cur_next      = link_rdata;
                    cnt_next      = cnt_reg + LINK_W'(1);
                    if ((link_rdata < NIL_LINK) && (cnt_reg != LAST_CNT))
                    begin
                        val_req.re     = 1'b1;
                        val_req.raddr  = link_rdata[SLOT_W-1:0];
                        link_req.re    = 1'b1;
                        link_req.raddr = link_rdata[SLOT_W-1:0];
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
                else
                begin
                    state_next = S_LINK;
                end
            end

            S_LINK:
            begin
                link_req.we    = 1'b1;
                link_req.waddr = r_reg;
                link_req.wdata = (cur_reg >= NIL_LINK) ? NIL_LINK : cur_reg;
                if (has_prev_reg)
                begin
                    state_next = S_LINK_PREV;
                end
                else
                begin
                    list_head_next = LINK_W'(r_reg);
                    state_next     = S_INS_DONE;
                end
            end

            S_LINK_PREV:
            begin
                link_req.we    = 1'b1;
                link_req.waddr = prev_reg;
                link_req.wdata = LINK_W'(r_reg);
                state_next     = S_INS_DONE;
            end

            S_INS_DONE:
            begin
                em_slot = slot_port(LINK_W'(r_reg));
                if (out_free)
                begin
                    em         = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_RD:
            begin
                if (list_head_reg >= NIL_LINK)
                begin
                    em_value  = '0;
                    em_status = STAT_EMPTY;
                    if (out_free)
                    begin
                        em         = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cur_next       = list_head_reg;
                    cnt_next       = '0;
                    val_req.re     = 1'b1;
                    val_req.raddr  = list_head_reg[SLOT_W-1:0];
                    link_req.re    = 1'b1;
                    link_req.raddr = list_head_reg[SLOT_W-1:0];
                    state_next     = S_RD_OUT;
                end
            end

            S_RD_OUT:
            begin
                em_value = val_rdata;
                em_slot  = slot_port(cur_reg);
                em_last  = fin;
                if (out_free)
                begin
                    em = 1'b1;
                    if (fin)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next       = link_rdata;
                        cnt_next       = cnt_reg + LINK_W'(1);
                        val_req.re     = 1'b1;
                        val_req.raddr  = link_rdata[SLOT_W-1:0];
                        link_req.re    = 1'b1;
                        link_req.raddr = link_rdata[SLOT_W-1:0];
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign res_valid = res_valid_reg;
    assign out_value = res_value_reg;
    assign slot      = res_slot_reg;
    assign status    = res_status_reg;
    assign last      = res_last_reg;

endmodule

// ===== rtl/sorted_list_with_free_pool_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_with_free_pool_core - sorted list in a fixed slot pool
// Top level: sequencer, value RAM and link store.
// ----------------------------------------------------------------------------
// One command is worked at a time; cmd_stall is high from acceptance until
// the command's last item is in the result register. The value and link
// memories each have one read port with registered read data, so the chain
// is walked one slot per cycle (a readout only while the result register is
// free). An insert fills the free head slot, walks past the smaller entries
// and links the slot in, relinking the entry before it, if any; a full pool
// answers FULL. A readout gives one item per entry, an empty one EMPTY.
// Clear is immediate, with no sweep; clear and unused codes give no item.
// ----------------------------------------------------------------------------
module sorted_list_with_free_pool_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [1:0]                          func,
    input  logic signed [slp_pkg::DATA_W-1:0]   value,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic signed [slp_pkg::DATA_W-1:0]   out_value,
    output logic [slp_pkg::SLOT_PORT_W-1:0]     slot,
    output logic [1:0]                          status,
    output logic                                last
);
    import slp_pkg::*;

    val_req_t          val_req;
    link_req_t         link_req;
    logic [DATA_W-1:0] val_rdata;
    logic [LINK_W-1:0] link_rdata;

    slp_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .func       (func),
        .value      (value),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_value  (out_value),
        .slot       (slot),
        .status     (status),
        .last       (last),
        .val_req    (val_req),
        .link_req   (link_req),
        .val_rdata  (val_rdata),
        .link_rdata (link_rdata)
    );

    slp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_req.we),
        .waddr (val_req.waddr),
        .wdata (val_req.wdata),
        .re    (val_req.re),
        .raddr (val_req.raddr),
        .rdata (val_rdata)
    );

    slp_link_store u_link (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (link_req),
        .rdata (link_rdata)
    );

`ifndef NO_ASSERTIONS
    a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && func == FUNC_INSERT |=> cmd_stall)
        else $error("insert accepted without going busy");

    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != STAT_OK |-> last)
        else $error("full or empty item not marked last");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == STAT_EMPTY |-> out_value == '0 && slot == '0)
        else $error("empty item carries data");

    a_link_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        link_req.we && link_req.re |-> link_req.waddr != link_req.raddr)
        else $error("link read and write on same slot");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for sorted_list_with_free_pool_core
// Feeds insert, readout, clear and unused commands through the valid/stall
// command port and tracks the sorted list and free chain in a local copy.
// Every result taken from the result port is compared against the oldest
// predicted item. Both sides idle in random bursts, and the receiver holds
// off once for a long stretch so that the core stalls its command input.
// ----------------------------------------------------------------------------
module tb;
    import slp_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         IDLE_LIMIT  = 3000;
    localparam int         DRAIN_WAIT  = 30;

    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] value;
    } list_cmd_t;

    typedef struct {
        logic signed [31:0]     value;
        logic [SLOT_PORT_W-1:0] slot;
        logic [1:0]             status;
        logic                   last;
    } list_result_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cmd_valid = 1'b0;
    logic                          cmd_stall;
    logic [1:0]                    func      = FUNC_READ;
    logic signed [DATA_W-1:0]      value     = '0;
    logic                          res_valid;
    logic                          res_stall = 1'b0;
    logic signed [DATA_W-1:0]      out_value;
    logic [SLOT_PORT_W-1:0]        slot;
    logic [1:0]                    status;
    logic                          last;

    wire cmd_fire = cmd_valid && !cmd_stall;
    wire res_fire = res_valid && !res_stall;

    list_cmd_t    cmd_queue[$];
    list_result_t list_results_due[$];

    // local copy of the pool
    logic signed [DATA_W-1:0] pool_val [SLOTS];
    logic [LINK_W-1:0]        pool_link[SLOTS];
    logic [LINK_W-1:0]        free_hd;
    logic [LINK_W-1:0]        list_hd;

    int   cmd_total   = 0;
    int   cmd_taken   = 0;
    int   mismatches  = 0;
    int   idle_cycles = 0;
    int   send_gap    = 0;
    int   recv_gap    = 0;
    logic cmd_acc     = 1'b0;
    logic hold_on     = 1'b0;

    sorted_list_with_free_pool_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .func      (func),
        .value     (value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_value (out_value),
        .slot      (slot),
        .status    (status),
        .last      (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic restore_pool();
        for (int i = 0; i < SLOTS; i++)
        begin
            pool_link[i] = (i == SLOTS - 1) ? NIL_LINK : LINK_W'(i + 1);
        end
        free_hd = '0;
        list_hd = NIL_LINK;
    endtask

    task automatic push_result(input logic signed [31:0] v, input logic [LINK_W-1:0] s,
                               input logic [1:0] st, input logic lst);
        list_result_t r;
        r.value  = v;
        r.slot   = s[SLOT_PORT_W-1:0];
        r.status = st;
        r.last   = lst;
        list_results_due.push_back(r);
    endtask

    task automatic list_predict(input logic [1:0] f, input logic signed [31:0] v);
        logic [LINK_W-1:0] fresh;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] nxt;
        bit                has_prev;
        int                steps;
        case (f)
            FUNC_INSERT:
            begin
                if (free_hd >= LINK_W'(SLOTS))
                begin
                    push_result(v, '0, STAT_FULL, 1'b1);
                end
                else
                begin
                    fresh = free_hd;
                    free_hd = pool_link[fresh[SLOT_W-1:0]];
                    pool_val[fresh[SLOT_W-1:0]] = v;
                    prev = '0;
                    has_prev = 0;
                    cur = list_hd;
                    steps = 0;
                    while (cur < LINK_W'(SLOTS) && steps < SLOTS
                           && pool_val[cur[SLOT_W-1:0]] < v)
                    begin
                        prev = cur;
                        has_prev = 1;
                        cur = pool_link[cur[SLOT_W-1:0]];
                        steps++;
                    end
                    if (cur >= LINK_W'(SLOTS))
                        cur = NIL_LINK;
                    if (has_prev)
                        pool_link[prev[SLOT_W-1:0]] = fresh;
                    else
                        list_hd = fresh;
                    pool_link[fresh[SLOT_W-1:0]] = cur;
                    push_result(v, fresh, STAT_OK, 1'b1);
                end
            end
            FUNC_READ:
            begin
                cur = list_hd;
                if (cur >= LINK_W'(SLOTS))
                begin
                    push_result('0, '0, STAT_EMPTY, 1'b1);
                end
                else
                begin
                    steps = 0;
                    while (cur < LINK_W'(SLOTS) && steps < SLOTS)
                    begin
                        nxt = pool_link[cur[SLOT_W-1:0]];
                        push_result(pool_val[cur[SLOT_W-1:0]], cur, STAT_OK,
                                    (nxt >= LINK_W'(SLOTS)) || (steps + 1 >= SLOTS));
                        steps++;
                        cur = nxt;
                    end
                end
            end
            FUNC_CLEAR:
                restore_pool();
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    endtask

    function automatic bit quiet_phase();
        return (cmd_queue.size() < 20) || (cmd_taken % 48 >= 36);
    endfunction

    function automatic logic signed [31:0] rand_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $signed($urandom_range(0, 8)) - 4;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_cmd(input logic [1:0] f, input logic signed [31:0] v,
                             inout int counted);
        list_cmd_t c;
        c.func  = f;
        c.value = v;
        cmd_queue.push_back(c);
        cmd_total++;
        if (f != FUNC_UNUSED)
            counted++;
    endtask

    // command driver
    always @(negedge clk)
    begin : feed
        list_cmd_t c;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (!cmd_valid || cmd_acc)
        begin
            if (send_gap > 0)
            begin
                cmd_valid <= 1'b0;
                send_gap--;
            end
            else if (cmd_queue.size() > 0)
            begin
                c = cmd_queue.pop_front();
                cmd_valid <= 1'b1;
                func <= c.func;
                value <= c.value;
                if (!quiet_phase() && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 7);
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin : sink
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else if (hold_on)
        begin
            res_stall <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            res_stall <= 1'b1;
            recv_gap--;
        end
        else
        begin
            res_stall <= 1'b0;
            if (!quiet_phase() && $urandom_range(0, 4) == 0)
                recv_gap = $urandom_range(1, 7);
        end
    end

    // long receiver hold-off so that the core backs up into its command port
    initial
    begin
        while (cmd_taken < 40)
            @(posedge clk);
        hold_on <= 1'b1;
        repeat (80) @(posedge clk);
        hold_on <= 1'b0;
    end

    // monitor: check results, then predict for the accepted command
    always @(posedge clk)
    begin : watch
        list_result_t want;
        if (rst_n)
        begin
            cmd_acc <= cmd_fire;
            if (res_fire)
            begin
                if (list_results_due.size() == 0)
                begin
                    report_mismatch("unexpected item", out_value, '0);
                end
                else
                begin
                    want = list_results_due.pop_front();
                    if (out_value !== want.value)
                        report_mismatch("out_value", out_value, want.value);
                    if (slot !== want.slot)
                        report_mismatch("slot", 32'(slot), 32'(want.slot));
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (last !== want.last)
                        report_mismatch("last", 32'(last), 32'(want.last));
                end
            end
            if (cmd_fire)
            begin
                list_predict(func, value);
                cmd_taken++;
            end
        end
    end

    always @(posedge clk)
    begin : dog
        if (cmd_fire || res_fire || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : main
        int counted;
        int n;
        counted = 0;
        restore_pool();
        for (int i = 0; i < SLOTS; i++)
            pool_val[i] = '0;

        // directed part
        queue_cmd(FUNC_READ, 32'sh5a5a5a5a, counted);
        queue_cmd(FUNC_INSERT, 32'sh7fffffff, counted);
        queue_cmd(FUNC_INSERT, 32'sh80000000, counted);
        queue_cmd(FUNC_INSERT, 32'sh00000000, counted);
        queue_cmd(FUNC_INSERT, -32'sd1, counted);
        queue_cmd(FUNC_INSERT, -32'sd1, counted);
        queue_cmd(FUNC_INSERT, 32'sh00000001, counted);
        queue_cmd(FUNC_READ, 32'shffffffff, counted);
        queue_cmd(FUNC_UNUSED, 32'sh12345678, counted);
        for (int i = 0; i < 10; i++)
            queue_cmd(FUNC_INSERT, rand_value(), counted);
        queue_cmd(FUNC_INSERT, 32'sh00000002, counted);
        queue_cmd(FUNC_READ, '0, counted);
        queue_cmd(FUNC_CLEAR, 32'sh7fffffff, counted);
        queue_cmd(FUNC_READ, '0, counted);

        // random sessions: mostly a clear, a run of inserts with stray readouts and unused codes, then a readout
        while (cmd_total < 100)
        begin
            if ($urandom_range(0, 3) != 0)
                queue_cmd(FUNC_CLEAR, $urandom, counted);
            n = $urandom_range(0, 19);
            for (int k = 0; k < n && cmd_total < 106; k++)
            begin
                queue_cmd(FUNC_INSERT, rand_value(), counted);
                if ($urandom_range(0, 5) == 0)
                    queue_cmd(FUNC_READ, $urandom, counted);
                if ($urandom_range(0, 15) == 0)
                    queue_cmd(FUNC_UNUSED, $urandom, counted);
            end
            queue_cmd(FUNC_READ, $urandom, counted);
        end

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_taken < cmd_total)
            @(posedge clk);
        while (list_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sorted_list_with_free_pool_core.f =====
rtl/slp_pkg.sv
rtl/slp_ram.sv
rtl/slp_link_store.sv
rtl/slp_seq.sv
rtl/sorted_list_with_free_pool_core.sv
verif/tb.sv
